// ===== design/b32_pkg.sv =====
// shared types, constants and character mapping for the base32 codec
`timescale 1ns / 1ps

package b32_pkg;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam int unsigned ACC_W = 12;
  localparam int unsigned CNT_W = 4;
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned IDX_W = 2;

  localparam logic [4:0] LETTER_COUNT = 5'd26;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHAR_TWO     = 8'h32;
  localparam logic [7:0] CHAR_SEVEN   = 8'h37;

  typedef struct packed {
    logic [7:0] value;
    logic       data_valid;
    logic       bad_char;
    logic       is_last;
  } result_t;

  typedef struct packed {
    logic [IDX_W-1:0]                count;
    result_t [MAX_RESULTS-1:0]       item;
  } result_set_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] bits;
  } char_bits_t;

  function automatic logic [7:0] enc_char(input logic [4:0] idx);
    logic [7:0] ch;
    if (idx < LETTER_COUNT) begin
      ch = CHAR_LOWER_A + 8'(idx);
    end else begin
      ch = CHAR_TWO + 8'(idx - LETTER_COUNT);
    end
    return ch;
  endfunction

  function automatic char_bits_t dec_char(input logic [7:0] ch);
    char_bits_t r;
    r = '0;
    if (ch inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
      r.ok   = 1'b1;
      r.bits = 5'(ch - CHAR_LOWER_A);
    end else if (ch inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
      r.ok   = 1'b1;
      r.bits = 5'(ch - CHAR_UPPER_A);
    end else if (ch inside {[CHAR_TWO:CHAR_SEVEN]}) begin
      r.ok   = 1'b1;
      r.bits = 5'(ch - CHAR_TWO) + LETTER_COUNT;
    end
    return r;
  endfunction

  function automatic logic [ACC_W-1:0] low_mask(input logic [CNT_W-1:0] n);
    return (ACC_W'(1) << n) - ACC_W'(1);
  endfunction

endpackage

// ===== design/base32_stream_codec.sv =====
// top level of the streaming base32 codec
`timescale 1ns / 1ps

// streaming base32 codec, lower-case alphabet, no padding. mode 0 encodes
// bytes to characters, mode 1 decodes characters (either case) to bytes.
// each request passes an input register, then combinational logic into a
// result register that sends one result per cycle while out_ready is high,
// so the result channel sets the rate: decoding takes one character per
// cycle; encoding gives one or two characters per byte, plus a flush
// character on a closing byte with bits left, and takes the next byte once
// they are sent. the first result is valid once the request reaches the
// result register. write mode only while idle; a write also clears any partial message.

module base32_stream_codec (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_value,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_value,
  output logic       data_valid,
  output logic       bad_char,
  output logic       out_last
);

  logic                 mode;
  logic                 in_full;
  logic [7:0]           value_q;
  logic                 last_q;
  logic                 in_full_next;
  logic                 step;
  logic                 can_load;
  logic                 accept;
  b32_pkg::result_set_t set;

  always_comb begin
    step         = in_full && can_load;
    in_ready     = !in_full || step;
    accept       = in_valid && in_ready;
    in_full_next = accept || (in_full && !step);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= b32_pkg::MODE_ENCODE;
      in_full <= 1'b0;
    end else begin
      if (cfg_write) begin
        mode <= cfg_data;
      end
      in_full <= in_full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_q <= in_value;
      last_q  <= in_last;
    end
  end

  b32_core u_core (
    .clk   (clk),
    .rst   (rst),
    .mode  (mode),
    .clear (cfg_write),
    .step  (step),
    .value (value_q),
    .last  (last_q),
    .set   (set)
  );

  b32_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .load       (step),
    .set_in     (set),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .data_valid (data_valid),
    .bad_char   (bad_char),
    .out_last   (out_last)
  );

  // encoded output never flags a bad character and always carries data
  a_enc_clean : assert property (@(posedge clk) disable iff (rst)
    out_valid && (mode == b32_pkg::MODE_ENCODE) |-> data_valid && !bad_char)
    else $error("encode result with marker or bad_char");

  // a pure marker closes its message with a zero value
  a_marker_last : assert property (@(posedge clk) disable iff (rst)
    out_valid && !data_valid |-> out_last && (out_value == 8'h00))
    else $error("marker result without out_last or with data");

  // a held request keeps its contents until the core takes it
  a_in_hold : assert property (@(posedge clk) disable iff (rst)
    in_full && !step |=> in_full && $stable(value_q) && $stable(last_q))
    else $error("input register lost a waiting request");

  // bad_char only ever appears on a closing result
  a_bad_on_last : assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_char |-> out_last && !data_valid)
    else $error("bad_char on a non-closing result");

endmodule

// ===== design/b32_core.sv =====
// bit accumulator state and per-request encode/decode logic
`timescale 1ns / 1ps

module b32_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 mode,
  input  logic                 clear,
  input  logic                 step,
  input  logic [7:0]           value,
  input  logic                 last,
  output b32_pkg::result_set_t set
);

  logic [b32_pkg::ACC_W-1:0] bit_accumulator;
  logic [b32_pkg::CNT_W-1:0] bit_count;
  logic                      skip_to_end;

  logic [b32_pkg::ACC_W-1:0] bit_accumulator_next;
  logic [b32_pkg::CNT_W-1:0] bit_count_next;
  logic                      skip_to_end_next;

  // encode path
  logic [b32_pkg::ACC_W-1:0] enc_acc;
  logic [b32_pkg::CNT_W-1:0] enc_cnt;
  logic [b32_pkg::CNT_W-1:0] enc_sh0;
  logic [b32_pkg::CNT_W-1:0] enc_sh1;
  logic [b32_pkg::CNT_W-1:0] enc_rem;
  logic [b32_pkg::ACC_W-1:0] enc_keep;
  logic                      enc_two;
  logic                      enc_flush;
  logic [7:0]                enc_c0;
  logic [7:0]                enc_c1;
  logic [7:0]                enc_cf;

  // decode path
  b32_pkg::char_bits_t       dc;
  logic [b32_pkg::ACC_W-1:0] dec_acc;
  logic [b32_pkg::CNT_W-1:0] dec_cnt;
  logic [b32_pkg::CNT_W-1:0] dec_rem;
  logic                      dec_adv;
  logic                      dec_emit;
  logic                      dec_skip;
  logic [7:0]                dec_byte;

  always_comb begin
    enc_acc   = {bit_accumulator[3:0], value};
    enc_cnt   = bit_count + b32_pkg::CNT_W'(8);
    enc_sh0   = enc_cnt - b32_pkg::CNT_W'(5);
    enc_sh1   = enc_cnt - b32_pkg::CNT_W'(10);
    enc_two   = (enc_cnt >= b32_pkg::CNT_W'(10));
    enc_rem   = enc_two ? enc_sh1 : enc_sh0;
    enc_keep  = enc_acc & b32_pkg::low_mask(enc_rem);
    enc_flush = last && (enc_rem != '0);
    enc_c0    = b32_pkg::enc_char(5'(enc_acc >> enc_sh0));
    enc_c1    = b32_pkg::enc_char(5'(enc_acc >> enc_sh1));
    enc_cf    = b32_pkg::enc_char(5'(enc_keep << (b32_pkg::CNT_W'(5) - enc_rem)));
  end

  always_comb begin
    dc       = b32_pkg::dec_char(value);
    dec_acc  = {bit_accumulator[6:0], dc.bits};
    dec_cnt  = bit_count + b32_pkg::CNT_W'(5);
    dec_adv  = !skip_to_end && dc.ok;
    dec_skip = skip_to_end || !dc.ok;
    dec_emit = dec_adv && (dec_cnt >= b32_pkg::CNT_W'(8));
    dec_rem  = dec_emit ? (dec_cnt - b32_pkg::CNT_W'(8)) : dec_cnt;
    dec_byte = 8'(dec_acc >> (dec_cnt - b32_pkg::CNT_W'(8)));
  end

  // result set and next state
  always_comb begin
    set                  = '0;
    bit_accumulator_next = bit_accumulator;
    bit_count_next       = bit_count;
    skip_to_end_next     = skip_to_end;
    if (mode == b32_pkg::MODE_ENCODE) begin
      set.count = b32_pkg::IDX_W'(1) + b32_pkg::IDX_W'(enc_two) + b32_pkg::IDX_W'(enc_flush);
      set.item[0].value = enc_c0;
      set.item[1].value = enc_two ? enc_c1 : enc_cf;
      set.item[2].value = enc_cf;
      for (int k = 0; k < b32_pkg::MAX_RESULTS; k++) begin
        set.item[k].data_valid = 1'b1;
        set.item[k].is_last    = last && (set.count == b32_pkg::IDX_W'(k + 1));
      end
      bit_accumulator_next = enc_keep;
      bit_count_next       = enc_rem;
    end else begin
      if (dec_emit) begin
        set.count                 = b32_pkg::IDX_W'(1);
        set.item[0].value         = dec_byte;
        set.item[0].data_valid    = 1'b1;
        set.item[0].is_last       = last;
      end else if (last) begin
        set.count                 = b32_pkg::IDX_W'(1);
        set.item[0].bad_char      = dec_skip;
        set.item[0].is_last       = 1'b1;
      end
      if (dec_adv) begin
        bit_accumulator_next = dec_acc & b32_pkg::low_mask(dec_rem);
        bit_count_next       = dec_rem;
      end
      skip_to_end_next = dec_skip;
    end
    if (last) begin
      bit_accumulator_next = '0;
      bit_count_next       = '0;
      skip_to_end_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      bit_accumulator <= '0;
      bit_count       <= '0;
      skip_to_end     <= 1'b0;
    end else if (step) begin
      bit_accumulator <= bit_accumulator_next;
      bit_count       <= bit_count_next;
      skip_to_end     <= skip_to_end_next;
    end
  end

endmodule

// ===== design/b32_outbuf.sv =====
// result register holding one request's result set, sent one per cycle while out_ready is high
`timescale 1ns / 1ps

module b32_outbuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  b32_pkg::result_set_t set_in,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_value,
  output logic                 data_valid,
  output logic                 bad_char,
  output logic                 out_last
);

  b32_pkg::result_set_t          set_q;
  logic [b32_pkg::IDX_W-1:0]     idx;
  logic                          busy;
  logic                          take;
  logic                          at_end;
  b32_pkg::result_t              cur;

  always_comb begin
    cur        = set_q.item[idx];
    take       = busy && out_ready;
    at_end     = (idx == set_q.count - b32_pkg::IDX_W'(1));
    can_load   = !busy || (take && at_end);
    out_valid  = busy;
    out_value  = cur.value;
    data_valid = cur.data_valid;
    bad_char   = cur.bad_char;
    out_last   = cur.is_last;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      set_q <= set_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= (set_in.count != '0);
      idx  <= '0;
    end else if (take && at_end) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (take) begin
      idx  <= idx + b32_pkg::IDX_W'(1);
    end
  end

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the streaming base32 codec in both modes
`timescale 1ns / 1ps

module testbench;

  localparam string B32_ALPHABET = "abcdefghijklmnopqrstuvwxyz234567";
  localparam int RANDOM_ITEMS = 170;
  localparam int SETTLE_CYCLES = 6;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_value = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_value;
  logic       data_valid;
  logic       bad_char;
  logic       out_last;

  // predicted codec state
  logic        cur_mode = b32_pkg::MODE_ENCODE;
  logic [11:0] bit_store = '0;
  logic [3:0]  bit_total = '0;
  logic        skipping = 1'b0;

  b32_pkg::result_t awaited[$];
  int      mismatch_count = 0;
  int      request_count = 0;
  int      ready_hold = 0;
  bit      quiet = 1'b0;

  base32_stream_codec dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_value   (in_value),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .data_valid (data_valid),
    .bad_char   (bad_char),
    .out_last   (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic note_mismatch(input string what, input int got, input int want);
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic b32_pkg::result_t make_result(input logic [7:0] v, input logic dv,
                                                   input logic bad, input logic fin);
    return {v, dv, bad, fin};
  endfunction

  // bit 5 set marks a character outside the alphabet
  function automatic logic [5:0] symbol_code(input logic [7:0] c);
    if (c >= b32_pkg::CHAR_LOWER_A && c <= b32_pkg::CHAR_LOWER_Z)
      return {1'b0, 5'(c - b32_pkg::CHAR_LOWER_A)};
    if (c >= b32_pkg::CHAR_UPPER_A && c <= b32_pkg::CHAR_UPPER_Z)
      return {1'b0, 5'(c - b32_pkg::CHAR_UPPER_A)};
    if (c >= b32_pkg::CHAR_TWO && c <= b32_pkg::CHAR_SEVEN)
      return {1'b0, 5'(c - b32_pkg::CHAR_TWO + 8'd26)};
    return 6'h20;
  endfunction

  function automatic void clear_codec();
    bit_store = '0;
    bit_total = '0;
    skipping = 1'b0;
  endfunction

  function automatic void advance_codec(input logic [7:0] v, input logic fin);
    b32_pkg::result_t outs[$];
    logic [5:0] code;
    logic [4:0] idx;
    if (cur_mode == b32_pkg::MODE_ENCODE) begin
      bit_store = {bit_store[3:0], v};
      bit_total = bit_total + 4'd8;
      while (bit_total >= 4'd5 && outs.size() < 2) begin
        bit_total = bit_total - 4'd5;
        idx = 5'(bit_store >> bit_total);
        outs = {outs, make_result(B32_ALPHABET[idx], 1'b1, 1'b0, 1'b0)};
      end
      bit_store = bit_store & ((12'd1 << bit_total) - 12'd1);
      if (fin) begin
        if (bit_total != 4'd0) begin
          idx = 5'(bit_store << (4'd5 - bit_total));
          outs = {outs, make_result(B32_ALPHABET[idx], 1'b1, 1'b0, 1'b0)};
        end
        outs[outs.size() - 1].is_last = 1'b1;
        clear_codec();
      end
    end else begin
      if (!skipping) begin
        code = symbol_code(v);
        if (code[5]) begin
          skipping = 1'b1;
        end else begin
          bit_store = {bit_store[6:0], code[4:0]};
          bit_total = bit_total + 4'd5;
          if (bit_total >= 4'd8) begin
            bit_total = bit_total - 4'd8;
            outs = {outs, make_result(8'(bit_store >> bit_total), 1'b1, 1'b0, 1'b0)};
          end
          bit_store = bit_store & ((12'd1 << bit_total) - 12'd1);
        end
      end
      if (fin) begin
        if (outs.size() > 0) begin
          outs[0].is_last = 1'b1;
          outs[0].bad_char = skipping;
        end else begin
          outs = {outs, make_result(8'h00, 1'b0, skipping, 1'b1)};
        end
        clear_codec();
      end
    end
    awaited = {awaited, outs};
  endfunction

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    b32_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited.size() == 0) begin
        note_mismatch("result with nothing awaited", out_value, 0);
      end else begin
        want = awaited.pop_front();
        if (out_value !== want.value) note_mismatch("out_value", out_value, want.value);
        if (data_valid !== want.data_valid)
          note_mismatch("data_valid", data_valid, want.data_valid);
        if (bad_char !== want.bad_char) note_mismatch("bad_char", bad_char, want.bad_char);
        if (out_last !== want.is_last) note_mismatch("out_last", out_last, want.is_last);
      end
      ready_hold = quiet ? 0 : $urandom_range(0, 3);
    end
  end

  // called at a falling edge; leaves the request up so the caller must drive in_valid next
  task automatic send_item(input logic [7:0] v, input logic fin);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_codec(v, fin);
    request_count++;
    @(negedge clk);
  endtask

  task automatic send_message(input logic [7:0] msg[$], input bit closed);
    foreach (msg[i]) send_item(msg[i], closed && (i == msg.size() - 1));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_mode(input logic m);
    drain_results();
    cfg_data  <= m;
    cfg_write <= 1'b1;
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_mode = m;
    clear_codec();
  endtask

  function automatic logic [7:0] random_symbol();
    int idx;
    idx = $urandom_range(0, 31);
    if (idx < 26)
      return ($urandom_range(0, 1) ? b32_pkg::CHAR_UPPER_A : b32_pkg::CHAR_LOWER_A)
             + 8'(idx);
    return b32_pkg::CHAR_TWO + 8'(idx - 26);
  endfunction

  function automatic logic [7:0] random_invalid();
    logic [7:0] c;
    logic [5:0] code;
    c = 8'($urandom_range(0, 255));
    code = symbol_code(c);
    while (!code[5]) begin
      c = 8'($urandom_range(0, 255));
      code = symbol_code(c);
    end
    return c;
  endfunction

  task automatic test_encode_edges();
    set_mode(b32_pkg::MODE_ENCODE);
    send_message('{8'h00}, 1'b1);
    send_message('{8'hff}, 1'b1);
    // two bytes leave one bit, so the closing byte gives three characters
    send_message('{8'hff, 8'h00}, 1'b1);
    // five bytes fill eight characters exactly, no flush
    send_message('{8'h66, 8'h6f, 8'h6f, 8'h62, 8'h61}, 1'b1);
  endtask

  task automatic test_decode_edges();
    set_mode(b32_pkg::MODE_DECODE);
    send_message('{"a"}, 1'b1);
    send_message('{"a", "z", "2", "7"}, 1'b1);
    send_message('{"A", "Z"}, 1'b1);
    // characters just outside each range
    send_message('{8'h60}, 1'b1);
    send_message('{"{"}, 1'b1);
    send_message('{"@"}, 1'b1);
    send_message('{"["}, 1'b1);
    send_message('{"1"}, 1'b1);
    send_message('{"8"}, 1'b1);
    // bad character mid message, rest is skipped
    send_message('{"b", "1", "c"}, 1'b1);
  endtask

  task automatic test_mode_switch_mid_message();
    set_mode(b32_pkg::MODE_DECODE);
    send_message('{"m"}, 1'b0);
    set_mode(b32_pkg::MODE_ENCODE);
    send_message('{8'h5a}, 1'b0);
    set_mode(b32_pkg::MODE_DECODE);
    send_message('{"a", "b"}, 1'b1);
  endtask

  task automatic test_random_traffic();
    logic [7:0] msg[$];
    int         phase;
    int         kind;
    int         len;
    int         target;
    phase = 0;
    target = request_count + RANDOM_ITEMS;
    while (request_count < target) begin
      quiet = (phase % 3 == 2);
      set_mode(logic'($urandom_range(0, 1)));
      repeat ($urandom_range(4, 8)) begin
        msg.delete();
        len = $urandom_range(1, 8);
        kind = $urandom_range(0, 9);
        repeat (len) begin
          if (cur_mode == b32_pkg::MODE_ENCODE || kind == 0)
            msg = {msg, 8'($urandom_range(0, 255))};
          else msg = {msg, random_symbol()};
        end
        if (cur_mode == b32_pkg::MODE_DECODE && kind == 1)
          msg[$urandom_range(0, len - 1)] = random_invalid();
        send_message(msg, 1'b1);
      end
      // sometimes leave a message unfinished for the next mode write to drop
      if ($urandom_range(0, 5) == 0) begin
        msg.delete();
        repeat ($urandom_range(1, 3)) begin
          msg = {msg, (cur_mode == b32_pkg::MODE_ENCODE) ? 8'($urandom_range(0, 255))
                                                         : random_symbol()};
        end
        send_message(msg, 1'b0);
      end
      phase++;
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_encode_edges();
    test_decode_edges();
    test_mode_switch_mid_message();
    test_random_traffic();
    drain_results();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
